/* rtl/core/adc_charge_pileup_subtract_core_assert.svh */
// assertion macros for the charge pileup subtraction core checker
// no dependencies; included by cps_checker.sv
`ifndef ADC_CHARGE_PILEUP_SUBTRACT_CORE_ASSERT_SVH
`define ADC_CHARGE_PILEUP_SUBTRACT_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cps assertion failed");

// next-cycle implication, disabled in reset
`define CPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cps assertion failed");

`endif

/* rtl/core/cps_pkg.sv */
// types, decode tables and reciprocal constants for the charge pileup subtraction core
// no dependencies; used by cps_decode, cps_decay, cps_scale and the top level
package cps_pkg;

   localparam int CHARGE_W = 19;

   typedef logic [CHARGE_W-1:0] charge_type;

   typedef struct packed {
      logic valid;
      logic ready;
   } ctl_type;

   typedef struct packed {
      charge_type q_earlier;
      charge_type q_current;
      logic [2:0] ndiv;
   } decode_data_type;

   typedef struct packed {
      charge_type q_current;
      charge_type decayed;
   } decay_data_type;

   typedef enum logic [1:0] {
      REG_FALL_TIME = 2'd0,
      REG_PEDESTAL  = 2'd1,
      REG_THRESHOLD = 2'd2
   } reg_index_type;

   localparam logic [5:0] FIRST_BIN [4] = '{6'd0, 6'd16, 6'd36, 6'd57};

   localparam charge_type EDGE_TAB [16] = '{
      19'd0,     19'd34,    19'd158,   19'd419,
      19'd517,   19'd915,   19'd1910,  19'd3990,
      19'd4780,  19'd7960,  19'd15900, 19'd32600,
      19'd38900, 19'd64300, 19'd128000, 19'd261000
   };

   localparam logic [13:0] SENS_TAB [16] = '{
      14'd3,    14'd6,    14'd12,   14'd25,
      14'd25,   14'd50,   14'd99,   14'd198,
      14'd198,  14'd397,  14'd794,  14'd1587,
      14'd1587, 14'd3174, 14'd6349, 14'd12700
   };

   localparam int DECAY_SHIFT = 26;
   localparam int DECAY_RECIP_W = 25;
   localparam int MAX_DECAY = 4;

   // ceil(2^26 / 3^n) for n = 1..4
   localparam logic [DECAY_RECIP_W-1:0] DECAY_RECIP [4] = '{
      25'(((2**DECAY_SHIFT) + 3 - 1) / 3),
      25'(((2**DECAY_SHIFT) + 9 - 1) / 9),
      25'(((2**DECAY_SHIFT) + 27 - 1) / 27),
      25'(((2**DECAY_SHIFT) + 81 - 1) / 81)
   };

   localparam int SCALED_W = 14;
   localparam int SCALE_PRESHIFT = 5;
   localparam int SCALE_SHIFT = 17;
   localparam int SCALE_RECIP_W = 15;
   // ceil(2^17 / 5), applied after dividing by 32
   localparam logic [SCALE_RECIP_W-1:0] SCALE_RECIP = 15'(((2**SCALE_SHIFT) + 5 - 1) / 5);

   function automatic charge_type decode_charge(input logic [7:0] code);
      logic [1:0]  rng;
      logic [5:0]  man;
      logic [1:0]  sub;
      logic [3:0]  k;
      logic [5:0]  off;
      logic [13:0] sens;
      rng  = code[7:6];
      man  = code[5:0];
      sub  = 2'(man > 6'd16) + 2'(man > 6'd36) + 2'(man > 6'd57);
      k    = {rng, sub};
      off  = man - FIRST_BIN[sub];
      sens = SENS_TAB[k];
      return EDGE_TAB[k] + (CHARGE_W'(off) * CHARGE_W'(sens))
         + CHARGE_W'(sens >> 1) - CHARGE_W'(1);
   endfunction

endpackage

/* rtl/core/cps_decode.sv */
// stage 1: decodes both adc codes into charge and derives the decay count
// depends on cps_pkg
module cps_decode (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [13:0]               earlier_word,
   input  logic [13:0]               current_word,
   input  logic                      data_ready,
   input  logic [5:0]                fall_time,
   output cps_pkg::ctl_type          ctl_out,
   output cps_pkg::decode_data_type  data_out
);

   cps_pkg::ctl_type         ctl_ff, ctl_in;
   cps_pkg::decode_data_type data_ff, data_in;

   logic [5:0]        ft;
   logic signed [9:0] gap;
   logic signed [9:0] ft1, ft2, ft3, ft4, ft5;
   logic              neg, ge2, ge3, ge4, ge5;

   always_comb begin
      ft  = (fall_time == 6'd0) ? 6'd1 : fall_time;
      gap = 10'sd50 + signed'({4'b0, earlier_word[5:0]})
            - signed'({4'b0, current_word[5:0]});
      ft1 = signed'({4'b0, ft});
      ft2 = ft1 + ft1;
      ft3 = ft2 + ft1;
      ft4 = ft2 + ft2;
      ft5 = ft4 + ft1;
      neg = (gap + ft1) <= 10'sd0;
      ge2 = gap >= ft2;
      ge3 = gap >= ft3;
      ge4 = gap >= ft4;
      ge5 = gap >= ft5;

      ctl_in.valid = in_valid;
      ctl_in.ready = data_ready;
      data_in.q_earlier = cps_pkg::decode_charge(earlier_word[13:6]);
      data_in.q_current = cps_pkg::decode_charge(current_word[13:6]);
      data_in.ndiv = neg ? 3'(cps_pkg::MAX_DECAY)
                         : 3'(ge2) + 3'(ge3) + 3'(ge4) + 3'(ge5);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign ctl_out  = ctl_ff;
   assign data_out = data_ff;

endmodule

/* rtl/core/cps_decay.sv */
// stage 2: divides the earlier charge by 3 per decay length with one reciprocal multiply
// depends on cps_pkg
module cps_decay (
   input  logic                      clock,
   input  logic                      reset,
   input  cps_pkg::ctl_type          ctl_in_word,
   input  cps_pkg::decode_data_type  data_in_word,
   output cps_pkg::ctl_type          ctl_out,
   output cps_pkg::decay_data_type   data_out
);

   localparam int PROD_W = cps_pkg::CHARGE_W + cps_pkg::DECAY_RECIP_W;

   cps_pkg::ctl_type        ctl_ff;
   cps_pkg::decay_data_type data_ff, data_in;

   logic [1:0]        recip_idx;
   logic [PROD_W-1:0] prod;

   always_comb begin
      recip_idx = 2'(data_in_word.ndiv - 3'd1);
      prod = PROD_W'(data_in_word.q_earlier)
             * PROD_W'(cps_pkg::DECAY_RECIP[recip_idx]);
      data_in.q_current = data_in_word.q_current;
      data_in.decayed = (data_in_word.ndiv == 3'd0)
                        ? data_in_word.q_earlier
                        : cps_pkg::CHARGE_W'(prod >> cps_pkg::DECAY_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in_word;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign ctl_out  = ctl_ff;
   assign data_out = data_ff;

endmodule

/* rtl/core/cps_scale.sv */
// stages 3 and 4: pedestal and pileup subtraction, scaling by 1/160, hit flag
// depends on cps_pkg
module cps_scale (
   input  logic                     clock,
   input  logic                     reset,
   input  cps_pkg::ctl_type         ctl_in_word,
   input  cps_pkg::decay_data_type  data_in_word,
   input  logic [9:0]               pedestal_offset,
   input  logic [11:0]              flag_threshold,
   output logic                     out_valid,
   output logic [11:0]              pulse_amplitude,
   output logic                     hit_flag,
   output logic                     ready_out
);

   localparam int DIFF_W = cps_pkg::CHARGE_W + 2;
   localparam int PROD_W = cps_pkg::SCALED_W + cps_pkg::SCALE_RECIP_W;

   cps_pkg::ctl_type              ctl3_ff;
   logic [cps_pkg::SCALED_W-1:0]  scaled_ff, scaled_in;
   logic signed [DIFF_W-1:0]      diff;

   logic                          valid_ff;
   logic                          ready_ff;
   logic [11:0]                   amp_ff, amp_in;
   logic                          flag_ff, flag_in;
   logic [PROD_W-1:0]             prod;
   logic [11:0]                   amp_raw;

   always_comb begin
      diff = signed'({2'b0, data_in_word.q_current})
             - signed'({2'b0, data_in_word.decayed})
             - signed'(DIFF_W'(pedestal_offset));
      scaled_in = (diff > DIFF_W'(0))
                  ? cps_pkg::SCALED_W'(diff >>> cps_pkg::SCALE_PRESHIFT)
                  : '0;
   end

   always_comb begin
      prod    = PROD_W'(scaled_ff) * PROD_W'(cps_pkg::SCALE_RECIP);
      amp_raw = 12'(prod >> cps_pkg::SCALE_SHIFT);
      amp_in  = ctl3_ff.ready ? amp_raw : 12'd0;
      flag_in = ctl3_ff.ready && (amp_raw >= flag_threshold);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff  <= '0;
         valid_ff <= 1'b0;
         ready_ff <= 1'b0;
      end else begin
         ctl3_ff  <= ctl_in_word;
         valid_ff <= ctl3_ff.valid;
         ready_ff <= ctl3_ff.ready;
      end
   end

   always_ff @(posedge clock) begin
      scaled_ff <= scaled_in;
      amp_ff    <= amp_in;
      flag_ff   <= flag_in;
   end

   assign out_valid       = valid_ff;
   assign pulse_amplitude = amp_ff;
   assign hit_flag        = flag_ff;
   assign ready_out       = ready_ff;

endmodule

/* rtl/core/adc_charge_pileup_subtract_core.sv */
// top level of the charge pileup subtraction core: csr registers and pipeline
// depends on cps_pkg, cps_decode, cps_decay, cps_scale
//
// Usage:
//   req channel: drive req_earlier_word, req_current_word and req_data_ready
//   with start high; the word is taken at the edge where start is high and busy
//   is low. busy is only high during reset, so one word can enter every cycle.
//   rsp channel: rsp_valid marks one cycle holding rsp_pulse_amplitude,
//   rsp_hit_flag and rsp_ready_out; the receiver cannot stall, so results are
//   never held back.
//   Pipeline: each word passes through the decode, decay multiply, subtract and
//   reciprocal scale registers in that order, one result per word.
//   Throughput: 1 word per cycle, set by the four-stage pipeline.
//   csr port: csr_wr_en with csr_index and csr_wdata writes fall_time (0),
//   pedestal_offset (1) or flag_threshold (2); other indexes are ignored.
//   Write only while the pipeline is empty.
//   Reset: synchronous; clears the pipeline valid bits and loads fall_time 2,
//   pedestal_offset 36 and flag_threshold 10.
module adc_charge_pileup_subtract_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [13:0] req_earlier_word,
   input  logic [13:0] req_current_word,
   input  logic        req_data_ready,
   output logic        rsp_valid,
   output logic [11:0] rsp_pulse_amplitude,
   output logic        rsp_hit_flag,
   output logic        rsp_ready_out,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata
);

   logic [5:0]  fall_time_ff;
   logic [9:0]  pedestal_ff;
   logic [11:0] threshold_ff;

   cps_pkg::ctl_type         dec_ctl;
   cps_pkg::decode_data_type dec_data;
   cps_pkg::ctl_type         dcy_ctl;
   cps_pkg::decay_data_type  dcy_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         fall_time_ff <= 6'd2;
         pedestal_ff  <= 10'd36;
         threshold_ff <= 12'd10;
      end else if (csr_wr_en) begin
         case (csr_index)
            cps_pkg::REG_FALL_TIME: fall_time_ff <= csr_wdata[5:0];
            cps_pkg::REG_PEDESTAL:  pedestal_ff  <= csr_wdata[9:0];
            cps_pkg::REG_THRESHOLD: threshold_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = reset;

   cps_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (start && !busy),
      .earlier_word (req_earlier_word),
      .current_word (req_current_word),
      .data_ready   (req_data_ready),
      .fall_time    (fall_time_ff),
      .ctl_out      (dec_ctl),
      .data_out     (dec_data)
   );

   cps_decay u_decay (
      .clock        (clock),
      .reset        (reset),
      .ctl_in_word  (dec_ctl),
      .data_in_word (dec_data),
      .ctl_out      (dcy_ctl),
      .data_out     (dcy_data)
   );

   cps_scale u_scale (
      .clock           (clock),
      .reset           (reset),
      .ctl_in_word     (dcy_ctl),
      .data_in_word    (dcy_data),
      .pedestal_offset (pedestal_ff),
      .flag_threshold  (threshold_ff),
      .out_valid       (rsp_valid),
      .pulse_amplitude (rsp_pulse_amplitude),
      .hit_flag        (rsp_hit_flag),
      .ready_out       (rsp_ready_out)
   );

endmodule

/* rtl/core/cps_checker.sv */
// port-level checker for the charge pileup subtraction core, bound to the top level
// depends on adc_charge_pileup_subtract_core_assert.svh
`include "adc_charge_pileup_subtract_core_assert.svh"

module cps_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [11:0] rsp_pulse_amplitude,
   input logic        rsp_hit_flag,
   input logic        rsp_ready_out
);

   `CPS_ASSERT_NOW(a_rsp_has_word, clock, reset, rsp_valid, $past(start && !busy, 4))
   `CPS_ASSERT_NOW(a_not_ready_zero, clock, reset, rsp_valid && !rsp_ready_out, (rsp_pulse_amplitude == 12'd0) && !rsp_hit_flag)
   `CPS_ASSERT_NOW(a_amp_range, clock, reset, rsp_valid, rsp_pulse_amplitude <= 12'd2147)
   `CPS_ASSERT_NEXT(a_busy_only_reset, clock, reset, !reset, !busy)

endmodule

bind adc_charge_pileup_subtract_core cps_checker u_cps_checker (.*);
